// ----- sv/ring_stride_decimator_bbox_top_macros.svh -----
// assertion macros for the ring stride decimator
// used by the top level; no other dependencies
`ifndef RING_STRIDE_DECIMATOR_BBOX_TOP_MACROS_SVH
`define RING_STRIDE_DECIMATOR_BBOX_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RSD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsd check failed");
`define RSD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsd check failed");
`else
`define RSD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RSD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/rsd_pkg.sv -----
// shared constants, types and the stride ladder for the ring stride decimator
// no dependencies
package rsd_pkg;

  localparam int COUNT_BITS      = 20;
  localparam int COORD_FRAC_BITS = 23;

  localparam int TGT_W     = 11;
  localparam int KEPT_W    = 11;
  localparam int LON_W     = 32;
  localparam int LAT_W     = 31;
  localparam int CNT_FLD_W = 20;

  localparam logic [TGT_W-1:0] TGT_RESET = 11'd140;

  // divider works on count + target - 1, one bit more than the count
  localparam int DIV_W     = COUNT_BITS + 1;
  localparam int DIV_CNT_W = (DIV_W > 1) ? $clog2(DIV_W) : 1;

  // input tdata layout
  localparam int IN_CNT_LSB   = 0;
  localparam int IN_LON_LSB   = IN_CNT_LSB + CNT_FLD_W;
  localparam int IN_LAT_LSB   = IN_LON_LSB + LON_W;
  localparam int IN_VALID_BIT = IN_LAT_LSB + LAT_W;
  localparam int IN_USED_W    = IN_VALID_BIT + 1;
  localparam int IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

  // output tdata layout
  localparam int OUT_USED_W = LON_W + LAT_W + LAT_W + LAT_W + LON_W + LON_W + 1;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

  localparam logic ACT_BEGIN    = 1'b0;
  localparam logic ACT_POINT    = 1'b1;
  localparam logic KIND_POINT   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_FEW   = 1'b1;

  localparam longint DEG90  = longint'(90) * (longint'(1) << COORD_FRAC_BITS);
  localparam longint DEG180 = longint'(180) * (longint'(1) << COORD_FRAC_BITS);

  localparam logic signed [LAT_W-1:0] NORTH_INIT = LAT_W'(-DEG90);
  localparam logic signed [LAT_W-1:0] SOUTH_INIT = LAT_W'(DEG90);
  localparam logic signed [LON_W-1:0] EAST_INIT  = LON_W'(-DEG180);
  localparam logic signed [LON_W-1:0] WEST_INIT  = LON_W'(DEG180);

  localparam int MIN_POINTS = 3;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [TGT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // fixed stride ladder by point count
  function automatic logic [COUNT_BITS-1:0] ladder_stride(input logic [COUNT_BITS-1:0] n);
    logic [COUNT_BITS-1:0] s;
    if (n > 20000)      s = COUNT_BITS'(64);
    else if (n > 12000) s = COUNT_BITS'(32);
    else if (n > 6000)  s = COUNT_BITS'(16);
    else if (n > 3000)  s = COUNT_BITS'(8);
    else if (n > 1500)  s = COUNT_BITS'(4);
    else if (n > 700)   s = COUNT_BITS'(2);
    else                s = COUNT_BITS'(1);
    return s;
  endfunction

endpackage

// ----- sv/rsd_divider.sv -----
// radix-2 restoring divider, one quotient bit per cycle
// depends on rsd_pkg
module rsd_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  rsd_pkg::div_req_t req,
  output rsd_pkg::div_rsp_t rsp
);
  import rsd_pkg::*;

  logic [TGT_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [TGT_W-1:0]     dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  logic [TGT_W:0]   rem_sh;
  logic [TGT_W+1:0] diff;

  always_comb begin
    rem_sh   = {rem_r, quo_r[DIV_W-1]};
    diff     = {1'b0, rem_sh} - {2'b00, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // no borrow means the shifted remainder covers the divisor
      if (!diff[TGT_W+1]) begin
        rem_nxt = diff[TGT_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[TGT_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ----- sv/ring_stride_decimator_bbox_top.sv -----
// ring stride decimator with bounding box: top level, sequencer and output stage
// depends on rsd_pkg, rsd_divider and ring_stride_decimator_bbox_top_macros.svh
// point transfer: result in the output register the cycle after the point is accepted
// begin transfer with count above target: input not ready while the divider computes the stride
// ring summary: pending after the final point, or after a short begin, loaded once the output register is free
// throughput: one point per cycle while the output is not stalled; input stalls while a summary is pending
// reset: synchronous active low, clears control, target to 140 and box to initial values
`include "ring_stride_decimator_bbox_top_macros.svh"
module ring_stride_decimator_bbox_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // config: target_points
  input  logic                           cfg_we,
  input  logic [rsd_pkg::TGT_W-1:0]      cfg_wdata,
  // in_tdata: point_count, lon, lat, coord_valid, zero pad
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [rsd_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: action
  input  logic                           in_tuser,
  // out_tdata: out_lon, out_lat, north, south, east, west, status, zero pad
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [rsd_pkg::OUT_DATA_W-1:0] out_tdata,
  // out_tuser: kind
  output logic                           out_tuser,
  output logic                           out_tlast
);
  import rsd_pkg::*;

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_DIV  = 1'b1;

  logic [0:0] state_r, state_nxt;

  // configuration
  logic [TGT_W-1:0] target_r, target_nxt;
  logic [TGT_W-1:0] tgt_eff;

  // ring state
  logic [COUNT_BITS-1:0] stride_r, stride_nxt;
  logic [COUNT_BITS-1:0] idx_r, idx_nxt;
  logic [COUNT_BITS-1:0] phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] len_r, len_nxt;
  logic                  ring_open_r, ring_open_nxt;
  logic [KEPT_W-1:0]     kept_r, kept_nxt;
  logic signed [LON_W-1:0] prev_lon_r, prev_lon_nxt;
  logic signed [LAT_W-1:0] prev_lat_r, prev_lat_nxt;
  logic signed [LAT_W-1:0] north_r, north_nxt;
  logic signed [LAT_W-1:0] south_r, south_nxt;
  logic signed [LON_W-1:0] east_r, east_nxt;
  logic signed [LON_W-1:0] west_r, west_nxt;

  // output stage: one result register plus a pending summary flag
  logic                    sum_pend_r, sum_pend_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    o_kind_r, o_kind_nxt;
  logic signed [LON_W-1:0] o_lon_r, o_lon_nxt;
  logic signed [LAT_W-1:0] o_lat_r, o_lat_nxt;
  logic signed [LAT_W-1:0] o_north_r, o_north_nxt;
  logic signed [LAT_W-1:0] o_south_r, o_south_nxt;
  logic signed [LON_W-1:0] o_east_r, o_east_nxt;
  logic signed [LON_W-1:0] o_west_r, o_west_nxt;
  logic                    o_status_r, o_status_nxt;
  logic                    o_last_r, o_last_nxt;

  // input fields
  logic [COUNT_BITS-1:0]   cnt_in;
  logic signed [LON_W-1:0] lon_in;
  logic signed [LAT_W-1:0] lat_in;
  logic                    valid_in;

  logic                  acc;
  logic                  out_free;
  logic                  final_pt;
  logic                  tried;
  logic                  dup;
  logic                  keep;
  logic [COUNT_BITS:0]   phase_inc;
  logic [COUNT_BITS:0]   idx_inc;

  div_req_t div_req;
  div_rsp_t div_rsp;

  rsd_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign cnt_in   = COUNT_BITS'(in_tdata[IN_CNT_LSB +: CNT_FLD_W]);
  assign lon_in   = in_tdata[IN_LON_LSB +: LON_W];
  assign lat_in   = in_tdata[IN_LAT_LSB +: LAT_W];
  assign valid_in = in_tdata[IN_VALID_BIT];

  // zero target acts as one
  assign tgt_eff = (target_r == '0) ? TGT_W'(1) : target_r;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && !sum_pend_r && out_free;
  assign acc       = in_tvalid && in_tready;

  // stride test on the current point
  assign idx_inc   = {1'b0, idx_r} + 1'b1;
  assign phase_inc = {1'b0, phase_r} + 1'b1;
  assign final_pt  = idx_inc >= {1'b0, len_r};
  assign tried     = (phase_r == '0) || final_pt;
  assign dup       = (kept_r != '0) && (lon_in == prev_lon_r) && (lat_in == prev_lat_r);
  assign keep      = tried && valid_in && !dup;

  always_comb begin
    state_nxt     = state_r;
    target_nxt    = target_r;
    stride_nxt    = stride_r;
    idx_nxt       = idx_r;
    phase_nxt     = phase_r;
    len_nxt       = len_r;
    ring_open_nxt = ring_open_r;
    kept_nxt      = kept_r;
    prev_lon_nxt  = prev_lon_r;
    prev_lat_nxt  = prev_lat_r;
    north_nxt     = north_r;
    south_nxt     = south_r;
    east_nxt      = east_r;
    west_nxt      = west_r;
    sum_pend_nxt  = sum_pend_r;
    out_valid_nxt = out_valid_r && !out_tready;
    o_kind_nxt    = o_kind_r;
    o_lon_nxt     = o_lon_r;
    o_lat_nxt     = o_lat_r;
    o_north_nxt   = o_north_r;
    o_south_nxt   = o_south_r;
    o_east_nxt    = o_east_r;
    o_west_nxt    = o_west_r;
    o_status_nxt  = o_status_r;
    o_last_nxt    = o_last_r;

    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'({1'b0, cnt_in} + DIV_W'(tgt_eff) - 1'b1);
    div_req.divisor  = tgt_eff;

    if (cfg_we) begin
      target_nxt = cfg_wdata;
    end

    // pending summary goes out once the result register is free
    if (sum_pend_r && out_free) begin
      sum_pend_nxt  = 1'b0;
      out_valid_nxt = 1'b1;
      o_kind_nxt    = KIND_SUMMARY;
      o_lon_nxt     = '0;
      o_lat_nxt     = '0;
      o_north_nxt   = north_r;
      o_south_nxt   = south_r;
      o_east_nxt    = east_r;
      o_west_nxt    = west_r;
      o_status_nxt  = (kept_r < KEPT_W'(MIN_POINTS)) ? STATUS_FEW : STATUS_OK;
      o_last_nxt    = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (acc && in_tuser == ACT_BEGIN) begin
          // a begin abandons any open ring
          north_nxt  = NORTH_INIT;
          south_nxt  = SOUTH_INIT;
          east_nxt   = EAST_INIT;
          west_nxt   = WEST_INIT;
          kept_nxt   = '0;
          idx_nxt    = '0;
          phase_nxt  = '0;
          len_nxt    = cnt_in;
          stride_nxt = ladder_stride(cnt_in);
          if (cnt_in < COUNT_BITS'(MIN_POINTS)) begin
            // short ring: summary only, with kept count zero it reports too few
            ring_open_nxt = 1'b0;
            sum_pend_nxt  = 1'b1;
          end else begin
            ring_open_nxt = 1'b1;
            if (cnt_in > tgt_eff) begin
              div_req.start = 1'b1;
              state_nxt     = ST_DIV;
            end
          end
        end else if (acc && ring_open_r) begin
          if (keep) begin
            prev_lon_nxt = lon_in;
            prev_lat_nxt = lat_in;
            if (kept_r != '1) begin
              kept_nxt = kept_r + 1'b1;
            end
            if (lat_in > north_r) north_nxt = lat_in;
            if (lat_in < south_r) south_nxt = lat_in;
            if (lon_in > east_r)  east_nxt  = lon_in;
            if (lon_in < west_r)  west_nxt  = lon_in;
            out_valid_nxt = 1'b1;
            o_kind_nxt    = KIND_POINT;
            o_lon_nxt     = lon_in;
            o_lat_nxt     = lat_in;
            o_north_nxt   = '0;
            o_south_nxt   = '0;
            o_east_nxt    = '0;
            o_west_nxt    = '0;
            o_status_nxt  = STATUS_OK;
            o_last_nxt    = 1'b0;
          end
          if (final_pt) begin
            // summary follows from the updated box
            sum_pend_nxt  = 1'b1;
            ring_open_nxt = 1'b0;
            idx_nxt       = '0;
            phase_nxt     = '0;
          end else begin
            idx_nxt = idx_inc[COUNT_BITS-1:0];
            if (phase_inc >= {1'b0, stride_r}) begin
              phase_nxt = '0;
            end else begin
              phase_nxt = phase_inc[COUNT_BITS-1:0];
            end
          end
        end
      end
      ST_DIV: begin
        // ceil(count / target) replaces the ladder value when larger
        if (div_rsp.done) begin
          if (div_rsp.quotient > DIV_W'(stride_r)) begin
            stride_nxt = COUNT_BITS'(div_rsp.quotient);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      target_r    <= TGT_RESET;
      stride_r    <= COUNT_BITS'(1);
      idx_r       <= '0;
      phase_r     <= '0;
      len_r       <= '0;
      ring_open_r <= 1'b0;
      kept_r      <= '0;
      north_r     <= NORTH_INIT;
      south_r     <= SOUTH_INIT;
      east_r      <= EAST_INIT;
      west_r      <= WEST_INIT;
      sum_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      target_r    <= target_nxt;
      stride_r    <= stride_nxt;
      idx_r       <= idx_nxt;
      phase_r     <= phase_nxt;
      len_r       <= len_nxt;
      ring_open_r <= ring_open_nxt;
      kept_r      <= kept_nxt;
      north_r     <= north_nxt;
      south_r     <= south_nxt;
      east_r      <= east_nxt;
      west_r      <= west_nxt;
      sum_pend_r  <= sum_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    // payload, no reset
    prev_lon_r <= prev_lon_nxt;
    prev_lat_r <= prev_lat_nxt;
    o_kind_r   <= o_kind_nxt;
    o_lon_r    <= o_lon_nxt;
    o_lat_r    <= o_lat_nxt;
    o_north_r  <= o_north_nxt;
    o_south_r  <= o_south_nxt;
    o_east_r   <= o_east_nxt;
    o_west_r   <= o_west_nxt;
    o_status_r <= o_status_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, o_status_r, o_west_r, o_east_r,
                       o_south_r, o_north_r, o_lat_r, o_lon_r};

  // divider only reports while the sequencer waits for it
  `RSD_ASSERT_IMP(a_done_in_div, clk, rst_n, div_rsp.done, state_r == ST_DIV)
  // a divider start puts the sequencer into the wait state
  `RSD_ASSERT_NXT(a_start_to_div, clk, rst_n, div_req.start, state_r == ST_DIV && !in_tready)
  // an open ring always has a nonzero stride and a phase below it
  `RSD_ASSERT_IMP(a_phase_in_range, clk, rst_n, ring_open_r && state_r == ST_IDLE,
                  stride_r != '0 && phase_r < stride_r)
  // only summaries end a run
  `RSD_ASSERT_IMP(a_last_is_summary, clk, rst_n, out_tvalid, out_tlast == (out_tuser == KIND_SUMMARY))

endmodule
